FILE: rtl/ts_block_marker_inserter_core_defines.svh
// Assertion macros shared by the marker inserter RTL.
`ifndef TS_BLOCK_MARKER_INSERTER_CORE_DEFINES_SVH
`define TS_BLOCK_MARKER_INSERTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TBMI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TBMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tbmi_pkg.sv
// Shared types, constants and CRC helper of the marker inserter.
package tbmi_pkg;

  // Framing
  localparam int unsigned PKT_WORDS        = 47;
  localparam int unsigned WIP_W            = 6;
  localparam int unsigned DATAGRAM_PACKETS = 7;
  localparam int unsigned QUEUE_DEPTH      = 4;

  // TS header and section constants
  localparam logic [7:0]  SYNC_BYTE   = 8'h47;
  localparam logic [12:0] NULL_PID    = 13'h1FFF;
  localparam logic [2:0]  HDR_PUSI    = 3'b010;
  localparam logic [3:0]  HDR_AFC     = 4'h1;
  localparam logic [7:0]  SECT_TID    = 8'hBF;
  localparam logic [7:0]  SECT_FLAGS  = 8'h30;
  localparam logic [7:0]  SECT_LEN    = 8'd24;
  localparam logic [31:0] STUFF_WORD  = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOADS_PER_MARKER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MK_PID              = 1'd1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [7:0]  PPM_RESET  = 8'd5;
  localparam logic [12:0] PID_RESET  = 13'h1FF0;

  // Marker packet word positions
  localparam int unsigned MW_W = 6;
  localparam logic [MW_W-1:0] MW_HEADER  = 6'd0;
  localparam logic [MW_W-1:0] MW_SECT_HD = 6'd1;
  localparam logic [MW_W-1:0] MW_NUMBER  = 6'd2;
  localparam logic [MW_W-1:0] MW_COUNTS  = 6'd3;
  localparam logic [MW_W-1:0] MW_START   = 6'd4;
  localparam logic [MW_W-1:0] MW_NEXT    = 6'd5;
  localparam logic [MW_W-1:0] MW_SOURCE  = 6'd6;
  localparam logic [MW_W-1:0] MW_CRC     = 6'd7;
  localparam logic [MW_W-1:0] MW_LAST    = 6'(PKT_WORDS - 1);

  // CRC-32/MPEG-2
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam int unsigned CRC_MSG_BYTES = 20;

  // One byte through the MSB-first CRC register
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // CRC state after the three fixed section header bytes
  localparam logic [31:0] CRC_INIT =
    crc_byte(crc_byte(crc_byte(CRC_SEED, SECT_TID), SECT_FLAGS), SECT_LEN);

  // Snapshot of everything a marker packet needs
  typedef struct packed {
    logic [3:0]  cc;
    logic [31:0] number;
    logic [15:0] data_pkts;
    logic [15:0] nulls;
    logic [15:0] start_seq;
    logic [15:0] next_seq;
    logic [31:0] source;
    logic        dg_end;
  } marker_t;

  // One queued item: the pass-through word plus an optional marker
  typedef struct packed {
    logic [31:0] word;
    logic        pkt_end;
    logic        dg_end;
    logic        short_pl;
    logic        marker;
    marker_t     mrk;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: rtl/ts_block_marker_inserter_core.sv
// Top level of the transport stream marker inserter.
// Payload words pass through the queue write and the output register at one word per clock
// while the output does not stall and no marker is being sent. After every payloads_per_marker
// payloads a 47-word marker packet follows the payload's last word; the marker's CRC-32 is
// computed one byte per cycle over 20 section bytes and the CRC word waits for it to finish.
// Input keeps flowing into the front queue meanwhile and is stalled only when that queue is full.
// The user must write configuration only while the block is idle; the block does not enforce it.
`include "ts_block_marker_inserter_core_defines.svh"

module ts_block_marker_inserter_core #(
  parameter int unsigned DatagramPackets = tbmi_pkg::DATAGRAM_PACKETS,
  parameter int unsigned QueueDepth      = tbmi_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [tbmi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tbmi_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] payload_word_i,
  input  logic [15:0] rtp_seq_i,
  input  logic [31:0] source_id_i,
  input  logic        payload_end_i,
  // output items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_word_o,
  output logic        packet_end_o,
  output logic        datagram_end_o,
  output logic        is_marker_o,
  output logic        short_payload_o,
  output logic        last_o
);

  logic [7:0]       ppm_q;
  logic [12:0]      pid_q;
  logic             push, pop;
  tbmi_pkg::item_t  push_item, head_item;
  tbmi_pkg::qstat_t qstat;
  logic             out_take, dg_word, mk_word, mk_flags_ok, mk_mid_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q <= tbmi_pkg::PPM_RESET;
      pid_q <= tbmi_pkg::PID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbmi_pkg::CFG_PAYLOADS_PER_MARKER: ppm_q <= cfg_wdata_i[7:0];
        tbmi_pkg::CFG_MK_PID:              pid_q <= cfg_wdata_i[12:0];
        default:                           ppm_q <= ppm_q;
      endcase
    end
  end

  tbmi_front #(
    .DatagramPackets (DatagramPackets)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ppm_i          (ppm_q),
    .in_valid_i     (in_valid_i),
    .payload_word_i (payload_word_i),
    .rtp_seq_i      (rtp_seq_i),
    .source_id_i    (source_id_i),
    .payload_end_i  (payload_end_i),
    .qstat_i        (qstat),
    .in_stall_o     (in_stall_o),
    .push_o         (push),
    .item_o         (push_item)
  );

  tbmi_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (qstat)
  );

  tbmi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mk_pid_i        (pid_q),
    .item_i          (head_item),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_o      (out_word_o),
    .packet_end_o    (packet_end_o),
    .datagram_end_o  (datagram_end_o),
    .is_marker_o     (is_marker_o),
    .short_payload_o (short_payload_o),
    .last_o          (last_o)
  );

  // Checks
  assign out_take    = out_valid_o && !out_stall_i;
  assign dg_word     = out_valid_o && datagram_end_o;
  assign mk_word     = out_valid_o && is_marker_o;
  assign mk_flags_ok = (last_o == packet_end_o) && !short_payload_o;
  assign mk_mid_take = out_take && is_marker_o && !packet_end_o;

  `TBMI_ASSERT_IMPLY(a_dg_on_pe, clk_i, rst_ni, dg_word, packet_end_o, "dg end off pkt end")
  `TBMI_ASSERT_IMPLY(a_mk_flags, clk_i, rst_ni, mk_word, mk_flags_ok, "marker word flags")
  `TBMI_ASSERT_NEXT(a_mk_runs, clk_i, rst_ni, mk_mid_take, is_marker_o, "marker cut short")

endmodule

FILE: rtl/tbmi_fifo.sv
// Short item queue between the front and back parts.
module tbmi_fifo #(
  parameter int unsigned Depth = tbmi_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tbmi_pkg::item_t item_i,
  input  logic            pop_i,
  output tbmi_pkg::item_t item_o,
  output tbmi_pkg::qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tbmi_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/tbmi_crc.sv
// Byte-serial CRC-32/MPEG-2 over the variable part of the marker section.
module tbmi_crc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [8*tbmi_pkg::CRC_MSG_BYTES-1:0] msg_i,
  output logic                 done_o,
  output logic [31:0]          crc_o
);

  localparam int unsigned NBytes = tbmi_pkg::CRC_MSG_BYTES;
  localparam int unsigned IdxW   = $clog2(NBytes);

  logic [7:0]      bytes [NBytes];
  logic [IdxW-1:0] idx_q, idx_d;
  logic            run_q, run_d, done_q, done_d;
  logic [31:0]     crc_q, crc_d;

  // First message byte sits in the top bits
  always_comb begin
    for (int i = 0; i < NBytes; i++) begin
      bytes[i] = msg_i[8*(NBytes-1-i) +: 8];
    end
  end

  // One byte per cycle
  always_comb begin
    idx_d  = idx_q;
    run_d  = run_q;
    done_d = done_q;
    crc_d  = crc_q;
    if (start_i) begin
      idx_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
      crc_d  = tbmi_pkg::CRC_INIT;
    end else if (run_q) begin
      crc_d = tbmi_pkg::crc_byte(crc_q, bytes[idx_q]);
      if (idx_q == IdxW'(NBytes - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign done_o = done_q;
  assign crc_o  = crc_q;

endmodule

FILE: rtl/tbmi_front.sv
// Front part: accepts payload words, frames and counts packets, decides markers.
module tbmi_front #(
  parameter int unsigned DatagramPackets = tbmi_pkg::DATAGRAM_PACKETS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       ppm_i,
  input  logic             in_valid_i,
  input  logic [31:0]      payload_word_i,
  input  logic [15:0]      rtp_seq_i,
  input  logic [31:0]      source_id_i,
  input  logic             payload_end_i,
  input  tbmi_pkg::qstat_t qstat_i,
  output logic             in_stall_o,
  output logic             push_o,
  output tbmi_pkg::item_t  item_o
);

  localparam int unsigned DgW  = $clog2(DatagramPackets + 1);
  localparam int unsigned WipW = tbmi_pkg::WIP_W;
  localparam logic [WipW-1:0] WipLast = WipW'(tbmi_pkg::PKT_WORDS - 1);

  // Datagram counter step: {wrapped, next count}
  function automatic logic [DgW:0] dg_tick(input logic [DgW-1:0] c);
    logic [DgW:0] inc;
    inc = {1'b0, c} + 1'b1;
    if (inc >= (DgW+1)'(DatagramPackets)) begin
      return {1'b1, {DgW{1'b0}}};
    end
    return {1'b0, inc[DgW-1:0]};
  endfunction

  logic [WipW-1:0] wip_q, wip_d;
  logic [7:0]      pib_q, pib_d;
  logic [15:0]     bss_q, bss_d, nn_q, nn_d, nl_q, nl_d;
  logic [31:0]     mn_q, mn_d;
  logic [3:0]      cc_q, cc_d;
  logic            seen_q, seen_d, mid_q, mid_d;
  logic            sync_q, sync_d, null_q, null_d;
  logic [DgW-1:0]  dg_q, dg_d;

  logic            accept, block_start, head, sync, isnull, pe, mk;
  logic [15:0]     nn_b, nl_b, bss_b, nn_n, nl_n, nxt;
  logic [DgW:0]    t1, t2;
  logic [DgW-1:0]  dg1;
  logic [WipW-1:0] wip_n;
  logic [7:0]      pib_inc;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign push_o     = accept;

  // Classification of the incoming word
  always_comb begin
    block_start = !mid_q && (pib_q == '0);
    nn_b  = block_start ? {15'h0, seen_q} : nn_q;
    nl_b  = block_start ? 16'h0 : nl_q;
    bss_b = block_start ? rtp_seq_i : bss_q;
    head   = (wip_q == '0);
    sync   = head ? (payload_word_i[31:24] == tbmi_pkg::SYNC_BYTE) : sync_q;
    isnull = head ? (payload_word_i[20:8] == tbmi_pkg::NULL_PID) : null_q;
    pe     = (wip_q >= WipLast);
    nn_n = nn_b;
    nl_n = nl_b;
    if (pe && sync) begin
      if (isnull) begin
        nl_n = nl_b + 1'b1;
      end else begin
        nn_n = nn_b + 1'b1;
      end
    end
    // packet end ticks the datagram first, a following marker ticks it again
    t1  = dg_tick(dg_q);
    dg1 = pe ? t1[DgW-1:0] : dg_q;
    t2  = dg_tick(dg1);
    wip_n   = (pe || payload_end_i) ? '0 : wip_q + 1'b1;
    pib_inc = pib_q + 1'b1;
    mk      = payload_end_i && (pib_inc >= ppm_i);
    nxt     = bss_b + {8'h0, ppm_i};

    item_o.word          = payload_word_i;
    item_o.pkt_end       = pe;
    item_o.dg_end        = pe && t1[DgW];
    item_o.short_pl      = payload_end_i && !pe;
    item_o.marker        = mk;
    item_o.mrk.cc        = cc_q;
    item_o.mrk.number    = mn_q;
    item_o.mrk.data_pkts = nn_n;
    item_o.mrk.nulls     = nl_n;
    item_o.mrk.start_seq = bss_b;
    item_o.mrk.next_seq  = nxt;
    item_o.mrk.source    = source_id_i;
    item_o.mrk.dg_end    = t2[DgW];
  end

  // State update on accept
  always_comb begin
    wip_d  = wip_q;
    pib_d  = pib_q;
    bss_d  = bss_q;
    nn_d   = nn_q;
    nl_d   = nl_q;
    mn_d   = mn_q;
    cc_d   = cc_q;
    seen_d = seen_q;
    mid_d  = mid_q;
    sync_d = sync_q;
    null_d = null_q;
    dg_d   = dg_q;
    if (accept) begin
      wip_d  = wip_n;
      sync_d = sync;
      null_d = isnull;
      nn_d   = nn_n;
      nl_d   = nl_n;
      bss_d  = bss_b;
      mid_d  = !payload_end_i;
      pib_d  = payload_end_i ? pib_inc : pib_q;
      dg_d   = dg1;
      if (mk) begin
        dg_d   = t2[DgW-1:0];
        cc_d   = cc_q + 1'b1;
        mn_d   = mn_q + 1'b1;
        seen_d = 1'b1;
        pib_d  = '0;
        bss_d  = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wip_q  <= '0;
      pib_q  <= '0;
      bss_q  <= '0;
      nn_q   <= '0;
      nl_q   <= '0;
      mn_q   <= 32'd1;
      cc_q   <= '0;
      seen_q <= 1'b0;
      mid_q  <= 1'b0;
      sync_q <= 1'b0;
      null_q <= 1'b0;
      dg_q   <= '0;
    end else begin
      wip_q  <= wip_d;
      pib_q  <= pib_d;
      bss_q  <= bss_d;
      nn_q   <= nn_d;
      nl_q   <= nl_d;
      mn_q   <= mn_d;
      cc_q   <= cc_d;
      seen_q <= seen_d;
      mid_q  <= mid_d;
      sync_q <= sync_d;
      null_q <= null_d;
      dg_q   <= dg_d;
    end
  end

endmodule

FILE: rtl/tbmi_back.sv
// Back part: drives pass-through words and generates marker packets.
module tbmi_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [12:0]      mk_pid_i,
  input  tbmi_pkg::item_t  item_i,
  input  tbmi_pkg::qstat_t qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      out_word_o,
  output logic             packet_end_o,
  output logic             datagram_end_o,
  output logic             is_marker_o,
  output logic             short_payload_o,
  output logic             last_o
);

  localparam int unsigned MwW = tbmi_pkg::MW_W;

  logic              valid_q, valid_d;
  logic [31:0]       word_q, word_d;
  logic              pe_q, pe_d, de_q, de_d, mk_q, mk_d, sh_q, sh_d, last_q, last_d;
  logic              act_q, act_d;
  logic [MwW-1:0]    idx_q, idx_d;
  tbmi_pkg::marker_t mrk_q, mrk_d;
  logic              load_en, crc_start, crc_done, mk_last;
  logic [31:0]       crc, mword;

  tbmi_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crc_start),
    .msg_i   ({mrk_q.number, mrk_q.data_pkts, mrk_q.nulls, 16'h0, mrk_q.start_seq,
               16'h0, mrk_q.next_seq, mrk_q.source}),
    .done_o  (crc_done),
    .crc_o   (crc)
  );

  // Marker packet word at the current position
  always_comb begin
    unique case (idx_q)
      tbmi_pkg::MW_HEADER:  mword = {tbmi_pkg::SYNC_BYTE, tbmi_pkg::HDR_PUSI, mk_pid_i,
                                     tbmi_pkg::HDR_AFC, mrk_q.cc};
      tbmi_pkg::MW_SECT_HD: mword = {8'h00, tbmi_pkg::SECT_TID, tbmi_pkg::SECT_FLAGS,
                                     tbmi_pkg::SECT_LEN};
      tbmi_pkg::MW_NUMBER:  mword = mrk_q.number;
      tbmi_pkg::MW_COUNTS:  mword = {mrk_q.data_pkts, mrk_q.nulls};
      tbmi_pkg::MW_START:   mword = {16'h0, mrk_q.start_seq};
      tbmi_pkg::MW_NEXT:    mword = {16'h0, mrk_q.next_seq};
      tbmi_pkg::MW_SOURCE:  mword = mrk_q.source;
      tbmi_pkg::MW_CRC:     mword = crc;
      default:              mword = tbmi_pkg::STUFF_WORD;
    endcase
  end

  assign load_en = !valid_q || !out_stall_i;
  assign mk_last = (idx_q == tbmi_pkg::MW_LAST);

  // Output register load: marker words first, else the next queued item
  always_comb begin
    valid_d   = valid_q;
    word_d    = word_q;
    pe_d      = pe_q;
    de_d      = de_q;
    mk_d      = mk_q;
    sh_d      = sh_q;
    last_d    = last_q;
    act_d     = act_q;
    idx_d     = idx_q;
    mrk_d     = mrk_q;
    pop_o     = 1'b0;
    crc_start = 1'b0;
    if (load_en) begin
      valid_d = 1'b0;
      if (act_q) begin
        // the CRC word waits for the serial CRC to finish
        if (idx_q != tbmi_pkg::MW_CRC || crc_done) begin
          valid_d = 1'b1;
          word_d  = mword;
          pe_d    = mk_last;
          de_d    = mk_last && mrk_q.dg_end;
          mk_d    = 1'b1;
          sh_d    = 1'b0;
          last_d  = mk_last;
          idx_d   = idx_q + 1'b1;
          if (mk_last) begin
            act_d = 1'b0;
          end
        end
      end else if (!qstat_i.empty) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        word_d  = item_i.word;
        pe_d    = item_i.pkt_end;
        de_d    = item_i.dg_end;
        mk_d    = 1'b0;
        sh_d    = item_i.short_pl;
        last_d  = !item_i.marker;
        if (item_i.marker) begin
          act_d     = 1'b1;
          idx_d     = '0;
          mrk_d     = item_i.mrk;
          crc_start = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      act_q   <= act_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    pe_q   <= pe_d;
    de_q   <= de_d;
    mk_q   <= mk_d;
    sh_q   <= sh_d;
    last_q <= last_d;
    mrk_q  <= mrk_d;
  end

  assign out_valid_o     = valid_q;
  assign out_word_o      = word_q;
  assign packet_end_o    = pe_q;
  assign datagram_end_o  = de_q;
  assign is_marker_o     = mk_q;
  assign short_payload_o = sh_q;
  assign last_o          = last_q;

endmodule
